// ===== hw/rtl/edmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edmc_pkg: shared types and constants
// Field widths, mode and register codes, lane weights and the wheel pattern
// of the encoder distance move controller.
// ----------------------------------------------------------------------------
package edmc_pkg;

	localparam int SPEED_W    = 8;
	localparam int TGT_W      = 17;
	localparam int TABS_W     = 16;
	localparam int MODE_W     = 3;
	localparam int ENC_W      = 32;
	localparam int NOW_W      = 32;
	localparam int DPC_W      = 20;
	localparam int TBASE_W    = 16;
	localparam int TPERCM_W   = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int KMUL_W     = 16;
	localparam int MULB_W     = DPC_W + KMUL_W;
	localparam int RHS_W      = TABS_W + 34;
	localparam int LIMP_W     = TABS_W + TPERCM_W;
	localparam int LIM_W      = LIMP_W - 4 + 1;
	localparam int LANES      = 4;

	localparam logic [KMUL_W-1:0] K_0888 = 16'd58196;

	localparam int SHIFT_STRAIGHT = 18;
	localparam int SHIFT_DIAG     = 17;
	localparam int SHIFT_SIDEWAYS = 34;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_STRAIGHT = 3'd1;
	localparam mode_t MODE_SIDEWAYS = 3'd2;
	localparam mode_t MODE_DIAG_A   = 3'd3;
	localparam mode_t MODE_DIAG_B   = 3'd4;

	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_DIST_PER_COUNT = 2'd0;
	localparam cfg_idx_t CFG_TIMEOUT_BASE   = 2'd1;
	localparam cfg_idx_t CFG_TIMEOUT_PER_CM = 2'd2;

	typedef logic [1:0] lane_idx_t;

	localparam lane_idx_t LANE_FL = 2'd0;
	localparam lane_idx_t LANE_FR = 2'd1;
	localparam lane_idx_t LANE_RL = 2'd2;
	localparam lane_idx_t LANE_RR = 2'd3;

	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 8'sh80;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sh7F;

	typedef enum logic [1:0] {
		W_ZERO  = 2'd0,
		W_PLUS  = 2'd1,
		W_MINUS = 2'd2
	} weight_t;

	typedef struct packed {
		logic    load;
		weight_t weight;
	} lane_ctl_t;

	function automatic weight_t lane_weight(mode_t mode, lane_idx_t lane);
		weight_t w;
		case (mode)
			MODE_STRAIGHT: w = W_PLUS;
			MODE_SIDEWAYS: w = (lane == LANE_FL || lane == LANE_RR) ? W_MINUS : W_PLUS;
			MODE_DIAG_A:   w = (lane == LANE_FR || lane == LANE_RL) ? W_PLUS : W_ZERO;
			MODE_DIAG_B:   w = (lane == LANE_FL || lane == LANE_RR) ? W_PLUS : W_ZERO;
			default:       w = W_ZERO;
		endcase
		return w;
	endfunction

	function automatic logic signed [SPEED_W-1:0] wheel_drive(mode_t mode,
			logic signed [SPEED_W-1:0] s, lane_idx_t lane);
		logic signed [SPEED_W-1:0] neg;
		logic signed [SPEED_W-1:0] d;
		neg = (s == SPEED_MIN) ? SPEED_MAX : -s;
		case (lane_weight(mode, lane))
			W_PLUS:  d = s;
			W_MINUS: d = neg;
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/edmc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edmc_if: channel interfaces
// Command, status and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface edmc_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  func;
	logic signed [edmc_pkg::SPEED_W-1:0]   speed;
	logic signed [edmc_pkg::TGT_W-1:0]     target_dist;
	logic        [edmc_pkg::MODE_W-1:0]    mode;
	logic signed [edmc_pkg::ENC_W-1:0]     enc_front_left;
	logic signed [edmc_pkg::ENC_W-1:0]     enc_front_right;
	logic signed [edmc_pkg::ENC_W-1:0]     enc_rear_left;
	logic signed [edmc_pkg::ENC_W-1:0]     enc_rear_right;
	logic        [edmc_pkg::NOW_W-1:0]     now_ms;

	modport source (output valid, func, speed, target_dist, mode, enc_front_left,
		enc_front_right, enc_rear_left, enc_rear_right, now_ms, input ready);
	modport sink (input valid, func, speed, target_dist, mode, enc_front_left,
		enc_front_right, enc_rear_left, enc_rear_right, now_ms, output ready);
endinterface

interface edmc_status_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [edmc_pkg::SPEED_W-1:0]   drive_front_left;
	logic signed [edmc_pkg::SPEED_W-1:0]   drive_front_right;
	logic signed [edmc_pkg::SPEED_W-1:0]   drive_rear_left;
	logic signed [edmc_pkg::SPEED_W-1:0]   drive_rear_right;
	logic                                  moving;
	logic                                  finished;
	logic                                  reached;

	modport source (output valid, drive_front_left, drive_front_right, drive_rear_left,
		drive_rear_right, moving, finished, reached, input ready);
	modport sink (input valid, drive_front_left, drive_front_right, drive_rear_left,
		drive_rear_right, moving, finished, reached, output ready);
endinterface

interface edmc_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [edmc_pkg::CFG_IDX_W-1:0]        index;
	logic [edmc_pkg::CFG_DATA_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/edmc_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edmc_lane: one wheel lane
// Forms the weighted count delta of one wheel against its baseline.
// ----------------------------------------------------------------------------
module edmc_lane #(
	parameter int COUNT_BITS = 32
) (
	input  logic                                clk,
	input  edmc_pkg::lane_ctl_t                 ctl,
	input  logic signed [edmc_pkg::ENC_W-1:0]   enc,
	input  logic        [COUNT_BITS-1:0]        base,
	output logic        [COUNT_BITS-1:0]        term_s1
);
	import edmc_pkg::*;

	logic [COUNT_BITS-1:0] enc_c;
	logic [COUNT_BITS-1:0] term_d;

	always_comb begin
		enc_c = COUNT_BITS'(enc);
		case (ctl.weight)
			W_PLUS:  term_d = enc_c - base;
			W_MINUS: term_d = base - enc_c;
			default: term_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			term_s1 <= term_d;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/edmc_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edmc_merge: lane merge
// Adds the four lane terms modulo the count width.
// ----------------------------------------------------------------------------
module edmc_merge #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [COUNT_BITS-1:0] term [4],
	output logic [COUNT_BITS-1:0] sum_s2
);
	always_ff @(posedge clk) begin
		if (load) begin
			sum_s2 <= (term[0] + term[1]) + (term[2] + term[3]);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/edmc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edmc_mul: serial multiplier
// Shift-add multiplier, one bit of the second operand per cycle, MSB first.
// ----------------------------------------------------------------------------
module edmc_mul #(
	parameter int A_W = 32,
	parameter int B_W = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] prod
);
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [P_W-1:0]   acc_q;

	assign busy = (cnt_q != '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(B_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : P_W'(0));
			b_q   <= {b_q[B_W-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/encoder_distance_move_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_distance_move_controller_unit: four-wheel move-by-distance control
// Start items latch baseline counts, target and timeout; sample items check
// the timeout, sum the wheel deltas in four lanes and test the distance.
// Start, idle, timeout and unknown-mode items go from accept to the done state;
// distance samples pass the lane, merge and multiply states, where they wait on
// the 36-step serial multiplier. A new item is taken only in the idle state.
// Reset: idle, no move, config registers at their defaults.
// ----------------------------------------------------------------------------
module encoder_distance_move_controller_unit #(
	parameter int COUNT_BITS = 32,
	parameter int TIME_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	edmc_cmd_if.sink      cmd,
	edmc_status_if.source status,
	edmc_cfg_if.sink      cfg
);
	import edmc_pkg::*;

	localparam int PROD_W = COUNT_BITS + MULB_W;
	localparam int CMP_W  = (PROD_W > RHS_W) ? PROD_W : RHS_W;
	localparam int LIMX_W = ((TIME_BITS > LIM_W) ? TIME_BITS : LIM_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LANE  = 5'b00010,
		S_MERGE = 5'b00100,
		S_MULT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [DPC_W-1:0]             dpc_q;
	logic [TBASE_W-1:0]           tbase_q;
	logic [TPERCM_W-1:0]          tpercm_q;
	logic [COUNT_BITS-1:0]        base_q [LANES];
	logic [TIME_BITS-1:0]         move_t0_q;
	logic [TIME_BITS-1:0]         limit_q;
	logic [TABS_W-1:0]            tabs_q;
	mode_t                        mode_q;
	logic signed [SPEED_W-1:0]    speed_q;
	logic                         active_q;
	logic                         fin_q;
	logic                         reach_q;
	logic [MULB_W-1:0]            mulb_q;
	logic                         out_valid_q;
	logic signed [SPEED_W-1:0]    drv_q [LANES];
	logic                         moving_q;
	logic                         finished_q;
	logic                         reached_q;

	logic                         cmd_acc;
	logic                         out_free;
	logic [TIME_BITS-1:0]         now_t;
	logic [TIME_BITS-1:0]         elapsed;
	logic                         timed_out;
	logic [TGT_W-1:0]             tgt_raw;
	logic [TGT_W-1:0]             tgt_mag;
	logic [TABS_W-1:0]            tabs_d;
	logic [LIMP_W-1:0]            lim_prod;
	logic [LIM_W-1:0]             lim_sum;
	logic [LIMX_W-1:0]            lim_ext;
	logic [LIMX_W-1:0]            tmax_ext;
	logic [TIME_BITS-1:0]         limit_d;
	logic                         mode_known;
	logic signed [ENC_W-1:0]      enc_now [LANES];
	lane_ctl_t                    lane_ctl [LANES];
	logic [COUNT_BITS-1:0]        term [4];
	logic [COUNT_BITS-1:0]        sum_s2;
	logic [COUNT_BITS-1:0]        mag;
	logic                         mul_busy;
	logic [PROD_W-1:0]            prod;
	logic [RHS_W-1:0]             rhs;
	logic                         reach_hit;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || status.ready;

	assign enc_now[LANE_FL] = cmd.enc_front_left;
	assign enc_now[LANE_FR] = cmd.enc_front_right;
	assign enc_now[LANE_RL] = cmd.enc_rear_left;
	assign enc_now[LANE_RR] = cmd.enc_rear_right;

	always_comb begin
		now_t     = TIME_BITS'(cmd.now_ms);
		elapsed   = now_t - move_t0_q;
		timed_out = elapsed > limit_q;

		tgt_raw = cmd.target_dist;
		tgt_mag = tgt_raw[TGT_W-1] ? (TGT_W'(0) - tgt_raw) : tgt_raw;
		tabs_d  = tgt_mag[TGT_W-1] ? {TABS_W{1'b1}} : tgt_mag[TABS_W-1:0];

		lim_prod = LIMP_W'(tabs_d) * LIMP_W'(tpercm_q);
		lim_sum  = LIM_W'(tbase_q) + LIM_W'(lim_prod[LIMP_W-1:4]);
		lim_ext  = LIMX_W'(lim_sum);
		tmax_ext = LIMX_W'({TIME_BITS{1'b1}});
		limit_d  = (lim_ext > tmax_ext) ? {TIME_BITS{1'b1}} : lim_ext[TIME_BITS-1:0];

		mode_known = mode_q inside {MODE_STRAIGHT, MODE_SIDEWAYS, MODE_DIAG_A, MODE_DIAG_B};

		mag = sum_s2[COUNT_BITS-1] ? (COUNT_BITS'(0) - sum_s2) : sum_s2;

		case (mode_q)
			MODE_SIDEWAYS: rhs = RHS_W'(tabs_q) << SHIFT_SIDEWAYS;
			MODE_STRAIGHT: rhs = RHS_W'(tabs_q) << SHIFT_STRAIGHT;
			default:       rhs = RHS_W'(tabs_q) << SHIFT_DIAG;
		endcase
		reach_hit = CMP_W'(prod) >= CMP_W'(rhs);
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign lane_ctl[i] = '{load: cmd_acc && (cmd.func == FUNC_SAMPLE),
			weight: lane_weight(mode_q, lane_idx_t'(i))};

		edmc_lane #(
			.COUNT_BITS(COUNT_BITS)
		) u_lane (
			.clk     (clk),
			.ctl     (lane_ctl[i]),
			.enc     (enc_now[i]),
			.base    (base_q[i]),
			.term_s1 (term[i])
		);
	end

	edmc_merge #(
		.COUNT_BITS(COUNT_BITS)
	) u_merge (
		.clk    (clk),
		.load   (state_q == S_LANE),
		.term   (term),
		.sum_s2 (sum_s2)
	);

	edmc_mul #(
		.A_W(COUNT_BITS),
		.B_W(MULB_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_MERGE),
		.a      (mag),
		.b      (mulb_q),
		.busy   (mul_busy),
		.prod   (prod)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_LANE) begin
			mulb_q <= (mode_q == MODE_SIDEWAYS) ? (MULB_W'(dpc_q) * MULB_W'(K_0888))
				: MULB_W'(dpc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q    <= '0;
			tbase_q  <= TBASE_W'(2000);
			tpercm_q <= TPERCM_W'(50);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_DIST_PER_COUNT: dpc_q    <= cfg.data[DPC_W-1:0];
				CFG_TIMEOUT_BASE:   tbase_q  <= cfg.data[TBASE_W-1:0];
				CFG_TIMEOUT_PER_CM: tpercm_q <= cfg.data[TPERCM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int i = 0; i < LANES; i++) begin
				base_q[i] <= '0;
			end
			move_t0_q    <= '0;
			limit_q      <= '0;
			tabs_q       <= '0;
			mode_q       <= '0;
			speed_q      <= '0;
			active_q     <= 1'b0;
			fin_q        <= 1'b0;
			reach_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						fin_q   <= 1'b0;
						reach_q <= 1'b0;
						if (cmd.func == FUNC_START) begin
							for (int i = 0; i < LANES; i++) begin
								base_q[i] <= COUNT_BITS'(enc_now[i]);
							end
							move_t0_q    <= now_t;
							limit_q      <= limit_d;
							tabs_q       <= tabs_d;
							mode_q       <= cmd.mode;
							speed_q      <= cmd.speed;
							active_q     <= 1'b1;
							state_q      <= S_DONE;
						end else if (!active_q) begin
							state_q <= S_DONE;
						end else if (timed_out) begin
							active_q <= 1'b0;
							fin_q    <= 1'b1;
							state_q  <= S_DONE;
						end else if (!mode_known) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_LANE;
						end
					end
				end
				S_LANE: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					if (!mul_busy) begin
						if (reach_hit) begin
							active_q <= 1'b0;
							fin_q    <= 1'b1;
							reach_q  <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			for (int i = 0; i < LANES; i++) begin
				drv_q[i] <= active_q ? wheel_drive(mode_q, speed_q, lane_idx_t'(i))
					: SPEED_W'(0);
			end
			moving_q   <= active_q;
			finished_q <= fin_q;
			reached_q  <= reach_q;
		end
	end

	assign status.valid             = out_valid_q;
	assign status.drive_front_left  = drv_q[LANE_FL];
	assign status.drive_front_right = drv_q[LANE_FR];
	assign status.drive_rear_left   = drv_q[LANE_RL];
	assign status.drive_rear_right  = drv_q[LANE_RR];
	assign status.moving            = moving_q;
	assign status.finished          = finished_q;
	assign status.reached           = reached_q;
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: encoder distance move controller
// Sends start and encoder sample items with random gaps on both channels,
// tracks the move state, baseline counts and timeout on its own, and checks
// every status item in order against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
	import edmc_pkg::*;

	localparam int ITEM_GOAL    = 1200;
	localparam int PHASE_ITEMS  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES  = 60;
	localparam int TAIL_LIMIT   = 5000;
	localparam int LONG_HOLD    = 400;
	localparam int REPORT_MAX   = 10;

	localparam mode_t MODE_IDLE   = 3'd0;
	localparam mode_t MODE_UNUSED = 3'd5;

	typedef logic [LANES-1:0][ENC_W-1:0] lane_counts_t;

	typedef struct packed {
		logic                      func;
		logic signed [SPEED_W-1:0] speed;
		logic signed [TGT_W-1:0]   target_dist;
		mode_t                     mode;
		lane_counts_t              enc;
		logic [NOW_W-1:0]          now_ms;
	} move_cmd_t;

	typedef struct packed {
		logic [LANES-1:0][SPEED_W-1:0] drive;
		logic                          moving;
		logic                          finished;
		logic                          reached;
	} move_status_t;

	class move_status_model;
		logic [DPC_W-1:0]          dist_per_count;
		logic [TBASE_W-1:0]        timeout_base;
		logic [TPERCM_W-1:0]       timeout_per_cm;
		lane_counts_t              baseline;
		logic [NOW_W-1:0]          move_t0;
		logic [NOW_W-1:0]          limit;
		logic [TABS_W-1:0]         target_abs;
		mode_t                     move_mode;
		logic signed [SPEED_W-1:0] move_speed;
		bit                        active;
		move_status_t              status_due[$];
		int                        failures;
		int                        reports;

		function new();
			dist_per_count = '0;
			timeout_base   = 16'd2000;
			timeout_per_cm = 10'd50;
			baseline       = '0;
			move_t0        = '0;
			limit          = '0;
			target_abs     = '0;
			move_mode      = MODE_IDLE;
			move_speed     = '0;
			active         = 1'b0;
			failures       = 0;
			reports        = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_DIST_PER_COUNT: dist_per_count = value[DPC_W-1:0];
				CFG_TIMEOUT_BASE:   timeout_base = value[TBASE_W-1:0];
				CFG_TIMEOUT_PER_CM: timeout_per_cm = value[TPERCM_W-1:0];
				default: ;
			endcase
		endfunction

		function move_status_t wheel_status(bit fin, bit reach);
			move_status_t st;
			logic signed [SPEED_W-1:0] s;
			logic signed [SPEED_W-1:0] n;
			logic signed [SPEED_W-1:0] z;
			s = move_speed;
			n = (s == SPEED_MIN) ? SPEED_MAX : -s;
			z = '0;
			st = '0;
			if (active) begin
				case (move_mode)
					MODE_STRAIGHT: st.drive = {s, s, s, s};
					MODE_SIDEWAYS: st.drive = {n, s, s, n};
					MODE_DIAG_A:   st.drive = {z, s, s, z};
					MODE_DIAG_B:   st.drive = {s, z, z, s};
					default:       st.drive = '0;
				endcase
			end
			st.moving   = active;
			st.finished = fin;
			st.reached  = reach;
			return st;
		endfunction

		function bit distance_reached(move_cmd_t c);
			lane_counts_t d;
			logic [ENC_W-1:0] sum;
			logic [ENC_W-1:0] mag;
			logic [MULB_W-1:0] mul;
			logic [RHS_W-1:0] rhs;
			logic [ENC_W+MULB_W-1:0] lhs;
			int i;
			for (i = 0; i < LANES; i++)
				d[i] = c.enc[i] - baseline[i];
			case (move_mode)
				MODE_STRAIGHT: sum = d[0] + d[1] + d[2] + d[3];
				MODE_SIDEWAYS: sum = d[1] + d[2] - d[0] - d[3];
				MODE_DIAG_A:   sum = d[1] + d[2];
				MODE_DIAG_B:   sum = d[0] + d[3];
				default:       return 1'b0;
			endcase
			mag = sum[ENC_W-1] ? -sum : sum;
			rhs = target_abs;
			if (move_mode == MODE_SIDEWAYS) begin
				mul = dist_per_count;
				mul = mul * K_0888;
				rhs = rhs << SHIFT_SIDEWAYS;
			end else begin
				mul = dist_per_count;
				rhs = rhs << ((move_mode == MODE_STRAIGHT) ? SHIFT_STRAIGHT : SHIFT_DIAG);
			end
			if (rhs == '0)
				return 1'b1;
			if (mul == '0)
				return 1'b0;
			lhs = mag;
			lhs = lhs * mul;
			return lhs >= rhs;
		endfunction

		function void accept_cmd(move_cmd_t c);
			logic [TGT_W-1:0] t;
			logic [TGT_W-1:0] mag17;
			logic [LIMP_W-1:0] prod;
			if (c.func == FUNC_START) begin
				t = c.target_dist;
				mag17 = t[TGT_W-1] ? -t : t;
				target_abs = mag17[TGT_W-1] ? '1 : mag17[TABS_W-1:0];
				baseline   = c.enc;
				move_t0    = c.now_ms;
				prod       = target_abs * timeout_per_cm;
				limit      = timeout_base + (prod >> 4);
				move_mode  = c.mode;
				move_speed = c.speed;
				active     = 1'b1;
				status_due.push_back(wheel_status(1'b0, 1'b0));
			end else if (!active) begin
				status_due.push_back(wheel_status(1'b0, 1'b0));
			end else if (c.now_ms - move_t0 > limit) begin
				active = 1'b0;
				status_due.push_back(wheel_status(1'b1, 1'b0));
			end else if (distance_reached(c)) begin
				active = 1'b0;
				status_due.push_back(wheel_status(1'b1, 1'b1));
			end else begin
				status_due.push_back(wheel_status(1'b0, 1'b0));
			end
		endfunction

		function string show(move_status_t s);
			return $sformatf("FL %0d FR %0d RL %0d RR %0d moving %b finished %b reached %b",
				$signed(s.drive[0]), $signed(s.drive[1]), $signed(s.drive[2]),
				$signed(s.drive[3]), s.moving, s.finished, s.reached);
		endfunction

		function void check_status(move_status_t got);
			move_status_t want;
			bit bad;
			int i;
			if (status_due.size() == 0) begin
				failures++;
				if (reports < REPORT_MAX) begin
					reports++;
					$display("%0t: status item with none pending: %s", $time, show(got));
				end
				return;
			end
			want = status_due.pop_front();
			bad = 1'b0;
			for (i = 0; i < LANES; i++)
				if (got.drive[i] !== want.drive[i])
					bad = 1'b1;
			if (got.moving !== want.moving || got.finished !== want.finished ||
					got.reached !== want.reached)
				bad = 1'b1;
			if (bad) begin
				failures++;
				if (reports < REPORT_MAX) begin
					reports++;
					$display("%0t: status mismatch", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	edmc_cmd_if    cmd_ch();
	edmc_status_if status_ch();
	edmc_cfg_if    cfg_ch();

	encoder_distance_move_controller_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	move_status_model model;
	bit quiet;
	bit hold_req;
	int items_sent;

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic lane_counts_t lanes(logic [ENC_W-1:0] fl, logic [ENC_W-1:0] fr,
			logic [ENC_W-1:0] rl, logic [ENC_W-1:0] rr);
		return {rr, rl, fr, fl};
	endfunction

	function automatic move_cmd_t random_cmd();
		move_cmd_t c;
		c.func        = $urandom_range(0, 1);
		c.speed       = $urandom;
		c.target_dist = $urandom;
		c.mode        = $urandom;
		c.enc         = {$urandom, $urandom, $urandom, $urandom};
		c.now_ms      = $urandom;
		return c;
	endfunction

	task automatic send_cmd(move_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid           <= 1'b1;
		cmd_ch.func            <= c.func;
		cmd_ch.speed           <= c.speed;
		cmd_ch.target_dist     <= c.target_dist;
		cmd_ch.mode            <= c.mode;
		cmd_ch.enc_front_left  <= c.enc[0];
		cmd_ch.enc_front_right <= c.enc[1];
		cmd_ch.enc_rear_left   <= c.enc[2];
		cmd_ch.enc_rear_right  <= c.enc[3];
		cmd_ch.now_ms          <= c.now_ms;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		model.accept_cmd(c);
		items_sent++;
	endtask

	task automatic send_start(logic signed [SPEED_W-1:0] speed,
			logic signed [TGT_W-1:0] tgt, mode_t mode, lane_counts_t enc,
			logic [NOW_W-1:0] now);
		move_cmd_t c;
		c             = random_cmd();
		c.func        = FUNC_START;
		c.speed       = speed;
		c.target_dist = tgt;
		c.mode        = mode;
		c.enc         = enc;
		c.now_ms      = now;
		send_cmd(c);
	endtask

	task automatic send_sample(lane_counts_t enc, logic [NOW_W-1:0] now);
		move_cmd_t c;
		c        = random_cmd();
		c.func   = FUNC_SAMPLE;
		c.enc    = enc;
		c.now_ms = now;
		send_cmd(c);
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (model.status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [DPC_W-1:0] dpc, logic [TBASE_W-1:0] base,
			logic [TPERCM_W-1:0] per_cm);
		cfg_idx_t idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		int i;
		idx[0] = CFG_DIST_PER_COUNT;
		idx[1] = CFG_TIMEOUT_BASE;
		idx[2] = CFG_TIMEOUT_PER_CM;
		val[0] = dpc;
		val[1] = base;
		val[2] = per_cm;
		drain_results();
		cfg_ch.valid <= 1'b1;
		for (i = 0; i < 3; i++) begin
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			model.write_reg(idx[i], val[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_move();
		mode_t move_modes [4];
		move_cmd_t c;
		lane_counts_t pos;
		logic [NOW_W-1:0] elapsed;
		logic [NOW_W-1:0] dt_max;
		logic [TGT_W-1:0] tmag;
		longint unsigned rhs;
		longint unsigned mul;
		longint unsigned need;
		longint inc;
		longint delta;
		int sgn [LANES];
		int steps;
		int width;
		int k;
		int i;
		int r;
		bit back;
		move_modes[0] = MODE_STRAIGHT;
		move_modes[1] = MODE_SIDEWAYS;
		move_modes[2] = MODE_DIAG_A;
		move_modes[3] = MODE_DIAG_B;
		c = random_cmd();
		c.func = FUNC_START;
		if ($urandom_range(0, 9) != 0)
			c.mode = move_modes[$urandom_range(0, 3)];
		if ($urandom_range(0, 9) != 0)
			c.speed = $urandom_range(0, 200) - 100;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: c.target_dist = '0;
				1: c.target_dist = 17'sh10000;
				2: c.target_dist = 17'sh0FFFF;
				default: c.target_dist = -17'sd1;
			endcase
		end else if (r < 70) begin
			tmag = $urandom_range(0, 2047);
			c.target_dist = $urandom_range(0, 1) ? -tmag : tmag;
		end
		send_cmd(c);

		rhs = model.target_abs;
		mul = model.dist_per_count;
		if (c.mode == MODE_SIDEWAYS) begin
			mul = mul * K_0888;
			rhs = rhs << SHIFT_SIDEWAYS;
		end else begin
			rhs = rhs << ((c.mode == MODE_STRAIGHT) ? SHIFT_STRAIGHT : SHIFT_DIAG);
		end
		need = (mul == 0) ? 64'h7FFF_FFFF : (rhs + mul - 1) / mul;
		steps = $urandom_range(1, 6);
		width = (c.mode == MODE_STRAIGHT || c.mode == MODE_SIDEWAYS) ? LANES : 2;
		inc = longint'(need / (width * steps)) + $urandom_range(0, 1);
		if (inc > (64'd1 << 27))
			inc = 64'd1 << 27;
		back = $urandom_range(0, 1);
		for (i = 0; i < LANES; i++) begin
			case (c.mode)
				MODE_STRAIGHT: sgn[i] = 1;
				MODE_SIDEWAYS: sgn[i] = (i == 0 || i == 3) ? -1 : 1;
				MODE_DIAG_A:   sgn[i] = (i == 1 || i == 2) ? 1 : 0;
				MODE_DIAG_B:   sgn[i] = (i == 0 || i == 3) ? 1 : 0;
				default:       sgn[i] = $urandom_range(0, 1);
			endcase
			if (back)
				sgn[i] = -sgn[i];
		end

		pos = c.enc;
		elapsed = '0;
		dt_max = model.limit / (steps + 1);
		for (k = 0; k < steps + 3 && model.active; k++) begin
			for (i = 0; i < LANES; i++) begin
				delta = sgn[i] * inc + $urandom_range(0, 2) - 1;
				pos[i] = pos[i] + delta[ENC_W-1:0];
			end
			r = $urandom_range(0, 99);
			if (r < 10)
				elapsed = model.limit + 1 + $urandom_range(0, 1000);
			else if (r < 14)
				elapsed = model.limit;
			else
				elapsed = elapsed + $urandom_range(0, dt_max);
			send_sample(pos, model.move_t0 + elapsed);
		end
	endtask

	initial begin
		model = new();
		status_ch.ready = 1'b0;
		begin
			int hold_left;
			hold_left = 0;
			forever begin
				@(posedge clk);
				if (status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
					model.check_status({status_ch.drive_rear_right, status_ch.drive_rear_left,
						status_ch.drive_front_right, status_ch.drive_front_left,
						status_ch.moving, status_ch.finished, status_ch.reached});
				if (hold_req) begin
					hold_req = 1'b0;
					hold_left = LONG_HOLD;
				end
				if (hold_left > 0) begin
					hold_left--;
					status_ch.ready <= 1'b0;
				end else begin
					hold_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
					status_ch.ready <= (hold_left == 0);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("encoder_distance_move_controller_unit: mismatch");
		$finish;
	end

	initial begin
		int phase;
		int phase_end;
		int waited;
		arst_n                 = 1'b0;
		quiet                  = 1'b0;
		hold_req               = 1'b0;
		items_sent             = 0;
		cmd_ch.valid           = 1'b0;
		cmd_ch.func            = FUNC_START;
		cmd_ch.speed           = '0;
		cmd_ch.target_dist     = '0;
		cmd_ch.mode            = MODE_IDLE;
		cmd_ch.enc_front_left  = '0;
		cmd_ch.enc_front_right = '0;
		cmd_ch.enc_rear_left   = '0;
		cmd_ch.enc_rear_right  = '0;
		cmd_ch.now_ms          = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = CFG_DIST_PER_COUNT;
		cfg_ch.data            = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: no distance scale, so only a zero target is reached
		send_sample(lanes(0, 0, 0, 0), 32'd0);
		send_start(8'sd100, 17'sd0, MODE_STRAIGHT, lanes(0, 0, 0, 0), 32'd5);
		send_sample(lanes(1, 1, 1, 1), 32'd6);
		send_start(-8'sd100, 17'sd16, MODE_STRAIGHT, lanes(0, 0, 0, 0), 32'd0);
		send_sample(lanes(32'h4000_0000, 32'h4000_0000, 0, 0), model.limit);
		send_sample(lanes(0, 0, 0, 0), model.limit + 1);

		set_config(20'hFFFFF, 16'hFFFF, 10'h3FF);
		send_start(8'sd100, 17'sd16, MODE_STRAIGHT, lanes(0, 0, 0, 0), 32'd0);
		send_sample(lanes(1, 1, 1, 1), 32'd10);
		send_sample(lanes(2, 1, 1, 1), 32'd20);
		send_start(SPEED_MIN, 17'sh10000, MODE_SIDEWAYS,
			lanes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 32'hFFFF_FFF0);
		send_sample(lanes(32'h7FFF_FC17, 32'h8000_03E7, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			32'h0000_0010);
		send_sample(lanes(32'h7FFF_FC17, 32'h8000_03E7, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			model.move_t0 + model.limit + 1);
		send_sample({$urandom, $urandom, $urandom, $urandom}, $urandom);
		send_start(8'sd127, 17'sd65535, MODE_DIAG_A, lanes(0, 0, 0, 0), 32'd1000);
		send_start(-8'sd100, 17'sd0, MODE_DIAG_B,
			lanes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 32'd2000);
		send_sample(lanes(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
			model.move_t0 + model.limit);
		send_start(8'sd50, 17'sd16, MODE_DIAG_A, lanes(0, 0, 0, 0), 32'd0);
		send_sample(lanes(5, -3, -2, 9), 32'd1);
		send_start(8'sd50, 17'sd32, MODE_UNUSED, lanes(0, 0, 0, 0), 32'd100);
		send_sample(lanes(32'h7000_0000, 32'h7000_0000, 32'h7000_0000, 32'h7000_0000),
			model.move_t0 + model.limit);
		send_sample(lanes(0, 0, 0, 0), model.move_t0 + model.limit + 1);
		send_start(-8'sd1, 17'sd0, MODE_IDLE, lanes(0, 0, 0, 0), 32'd0);
		send_sample(lanes(0, 0, 0, 0), 32'd1);
		send_start(8'sd1, -17'sd1, MODE_DIAG_B, lanes(0, 0, 0, 0), 32'hFFFF_FFFF);
		send_sample(lanes(-1, 0, 0, 0), 32'd0);

		for (phase = 0; items_sent < ITEM_GOAL; phase++) begin
			case (phase % 4)
				0: set_config('0, '0, '0);
				1: set_config('1, '1, '1);
				default: set_config($urandom_range(1024, 20'hFFFFF), $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 10'h3FF));
			endcase
			quiet = (phase % 3 == 2);
			if (phase == 2)
				hold_req = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 15)
					send_cmd(random_cmd());
				else
					run_move();
				if ($urandom_range(0, 99) < 3)
					drain_results();
			end
		end

		cmd_ch.valid <= 1'b0;
		waited = 0;
		while (model.status_due.size() != 0 && waited < TAIL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		model.failures += model.status_due.size();
		if (model.failures == 0)
			$display("encoder_distance_move_controller_unit: match");
		else
			$display("encoder_distance_move_controller_unit: mismatch");
		$finish;
	end

endmodule
